@@ src/qau_pkg.sv @@
// Package for the quaternion arithmetic unit: operation codes, widths and the
// rounding/saturation helpers used by the execution unit.
// No dependencies.
`default_nettype none
package qau_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 24;
  localparam int ProdBits = 2 * WordBits;
  // Sum of four products, shifted left by one, plus headroom.
  localparam int AccBits  = 2 * WordBits + 4;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = 2;
  // Dividend width of the inverse divider: one component moved up by
  // 2*FracBits+1 bits plus the squared norm.
  localparam int DivBits  = 2 * FracBits + WordBits + 2;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic signed [AccBits-1:0]  acc_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_MUL  = 3'd1,
    OP_CONJ = 3'd2,
    OP_INV  = 3'd3,
    OP_ROT  = 3'd4,
    OP_MAT  = 3'd5
  } op_t;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    logic [2:0] kind;
    logic       bad;
    word_t      a_s;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      b_s;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
  } item_t;

  typedef struct packed {
    word_t s;
    word_t x;
    word_t y;
    word_t z;
    logic  fault;
    logic  last;
  } res_t;

  // Saturate a wide signed value to one word; flag on overflow.
  function automatic word_t sat_word(input acc_t v, output logic ovf);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[AccBits-1:WordBits-1];
    hi_zeros = ~|v[AccBits-1:WordBits-1];
    ovf = ~(hi_ones | hi_zeros);
    if (ovf) begin
      sat_word = v[AccBits-1] ? {1'b1, {(WordBits-1){1'b0}}}
                              : {1'b0, {(WordBits-1){1'b1}}};
    end else begin
      sat_word = v[WordBits-1:0];
    end
  endfunction

  // Round to nearest (ties up) by FracBits, then saturate.
  function automatic word_t rnd_sat(input acc_t v, output logic ovf);
    acc_t t;
    t = (v + (acc_t'(1) <<< (FracBits - 1))) >>> FracBits;
    rnd_sat = sat_word(t, ovf);
  endfunction

endpackage
`default_nettype wire

@@ src/qau_front.sv @@
// Front end of the quaternion unit: accepts input transactions, classifies the
// operation kind and pushes items into a short queue. Depends on qau_pkg.
`default_nettype none
module qau_front
  import qau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire item_t       in_item,
  output logic             q_valid,
  input  wire logic        q_ready,
  output item_t            q_item
);

  item_t              mem [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [QueueAw:0]   count;
  logic               push;
  logic               pop;
  item_t              cls;

  // Mark unused operation codes so the back end only forwards a fault.
  always_comb begin
    cls = in_item;
    cls.bad = (in_item.kind > OP_MAT);
  end

  assign in_ready = (count != (QueueAw+1)'(QueueDepth));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ src/qau_div.sv @@
// Iterative restoring divider for the inverse operation, one quotient bit per
// cycle. Depends on qau_pkg.
`default_nettype none
module qau_div
  import qau_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DivBits-1:0] num,
  input  wire logic [DivBits-1:0] den,
  output logic                    busy,
  output logic                    done,
  output logic [DivBits-1:0]      quo
);

  localparam int CntBits = $clog2(DivBits + 1);

  logic [DivBits-1:0] n_reg;
  logic [DivBits:0]   rem;
  logic [DivBits:0]   rem_sh;
  logic [CntBits-1:0] cnt;

  assign rem_sh = {rem[DivBits-1:0], n_reg[DivBits-1]};

  // One shift-subtract step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CntBits'(DivBits);
        n_reg <= num;
        rem   <= '0;
        quo   <= '0;
      end else if (busy) begin
        n_reg <= n_reg << 1;
        if (rem_sh >= {1'b0, den}) begin
          rem <= rem_sh - {1'b0, den};
          quo <= {quo[DivBits-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[DivBits-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ src/qau_exec.sv @@
// Back end of the quaternion unit: pipelined Hamilton products and sums, a
// sequenced inverse and matrix output, and an output skid register.
// Depends on qau_pkg and qau_div.
`default_nettype none
module qau_exec
  import qau_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire item_t q_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res
);

  typedef enum logic [4:0] {
    ST_RUN  = 5'b00001,
    ST_ROT2 = 5'b00010,
    ST_INV  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_MAT  = 5'b10000
  } st_t;

  st_t   st;
  // Stage 1 register: item and sixteen products.
  logic  s1_valid;
  item_t s1_item;
  logic [1:0] s1_pass;
  logic  s1_hold;
  logic signed [ProdBits-1:0] p [4][4];
  // Stage 2: result waiting in skid register.
  logic  o_valid;
  logic  o_load;
  res_t  o_res;
  logic  o_free;

  // Second rotate pass operands and matrix column counter.
  word_t pr [4];
  logic  pr_f;
  logic [1:0] col;
  acc_t  mat [3][3];

  // Inverse sequencing.
  acc_t  nrm;
  logic [1:0] inv_i;
  logic  inv_all;
  word_t inv_r [4];
  logic  inv_f;
  logic  div_start;
  logic  div_busy;
  logic  div_done;
  logic [DivBits-1:0] div_num;
  logic [DivBits-1:0] div_den;
  logic [DivBits-1:0] div_quo;
  logic  inv_neg;

  word_t ma [4];
  logic signed [WordBits:0] mbx [4];
  logic  mult_go;

  assign o_free = !o_valid || out_ready;
  assign out_valid = o_valid;
  assign out_res = o_res;

  // Multiplier operand selection: pass 1 takes A and B, the rotate second pass
  // takes the intermediate and the conjugate of A. Inverse and matrix square A.
  always_comb begin
    word_t a_v [4];
    word_t b_v [4];
    a_v[0] = q_item.a_s; a_v[1] = q_item.a_x; a_v[2] = q_item.a_y; a_v[3] = q_item.a_z;
    b_v[0] = q_item.b_s; b_v[1] = q_item.b_x; b_v[2] = q_item.b_y; b_v[3] = q_item.b_z;
    if (q_item.kind == OP_ROT) b_v[0] = '0;
    if (q_item.kind == OP_MAT || q_item.kind == OP_INV) b_v = a_v;
    if (st == ST_ROT2) begin
      ma = pr;
      for (int j = 0; j < 4; j++) begin
        mbx[j] = (j == 0) ? $signed({a_v[j][WordBits-1], a_v[j]})
                          : -$signed({a_v[j][WordBits-1], a_v[j]});
      end
    end else begin
      ma = a_v;
      for (int j = 0; j < 4; j++) begin
        mbx[j] = $signed({b_v[j][WordBits-1], b_v[j]});
      end
    end
  end

  // Stage 1 is held while a multi-pass item waits for its sequencing.
  assign s1_hold = s1_valid && (s1_pass == 2'd0) &&
                   (s1_item.kind == OP_ROT || s1_item.kind == OP_INV ||
                    s1_item.kind == OP_MAT);

  // Items leave the queue once their multiply pass is issued; inverse, matrix
  // and rotate hold it until their later passes are done.
  always_comb begin
    mult_go = 1'b0;
    q_ready = 1'b0;
    unique case (st)
      ST_RUN: begin
        mult_go = q_valid && o_free && !s1_hold;
        q_ready = mult_go && !(q_item.kind == OP_ROT || q_item.kind == OP_INV ||
                              q_item.kind == OP_MAT);
      end
      ST_ROT2: begin
        mult_go = o_free && !s1_valid;
        q_ready = mult_go;
      end
      ST_INV: begin
        q_ready = o_free && (nrm == '0 || inv_all);
      end
      ST_DIV: begin
        q_ready = 1'b0;
      end
      default: begin
        q_ready = o_free && (col == 2'd3);
      end
    endcase
  end

  // Stage 1: sixteen products of the two operand sets.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (o_free) begin
      s1_valid <= mult_go;
    end
    if (mult_go) begin
      s1_item <= q_item;
      s1_pass <= (st == ST_ROT2) ? 2'd1 : 2'd0;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p[i][j] <= ma[i] * mbx[j];
        end
      end
    end
  end

  // Hamilton combination of the registered products.
  acc_t hs, hx, hy, hz;
  always_comb begin
    hs = acc_t'(p[0][0]) - acc_t'(p[1][1]) - acc_t'(p[2][2]) - acc_t'(p[3][3]);
    hx = acc_t'(p[0][1]) + acc_t'(p[1][0]) + acc_t'(p[2][3]) - acc_t'(p[3][2]);
    hy = acc_t'(p[0][2]) + acc_t'(p[2][0]) + acc_t'(p[3][1]) - acc_t'(p[1][3]);
    hz = acc_t'(p[0][3]) + acc_t'(p[3][0]) + acc_t'(p[1][2]) - acc_t'(p[2][1]);
  end

  // Simple results for add, conjugate and unused codes.
  res_t simple;
  always_comb begin
    acc_t sa [4];
    logic ov [4];
    word_t wa [4];
    word_t wb [4];
    wa[0] = s1_item.a_s; wa[1] = s1_item.a_x; wa[2] = s1_item.a_y; wa[3] = s1_item.a_z;
    wb[0] = s1_item.b_s; wb[1] = s1_item.b_x; wb[2] = s1_item.b_y; wb[3] = s1_item.b_z;
    for (int i = 0; i < 4; i++) begin
      if (s1_item.kind == OP_ADD) sa[i] = acc_t'(wa[i]) + acc_t'(wb[i]);
      else if (i == 0) sa[i] = acc_t'(wa[0]);
      else sa[i] = -acc_t'(wa[i]);
      ov[i] = 1'b0;
    end
    simple.s = sat_word(sa[0], ov[0]);
    simple.x = sat_word(sa[1], ov[1]);
    simple.y = sat_word(sa[2], ov[2]);
    simple.z = sat_word(sa[3], ov[3]);
    simple.fault = ov[0] | ov[1] | ov[2] | ov[3];
    simple.last = 1'b1;
    if (s1_item.bad) begin
      simple = '0;
      simple.fault = 1'b1;
      simple.last = 1'b1;
    end
  end

  // Rounded Hamilton result.
  word_t hr [4];
  logic  hov [4];
  always_comb begin
    hr[0] = rnd_sat(hs, hov[0]);
    hr[1] = rnd_sat(hx, hov[1]);
    hr[2] = rnd_sat(hy, hov[2]);
    hr[3] = rnd_sat(hz, hov[3]);
  end

  // Matrix column rounding.
  res_t mcol;
  always_comb begin
    logic ov [4];
    acc_t one;
    one = acc_t'(1) <<< (2 * FracBits);
    mcol = '0;
    for (int i = 0; i < 4; i++) ov[i] = 1'b0;
    if (col == 2'd3) begin
      mcol.z = rnd_sat(one, ov[3]);
    end else begin
      mcol.s = rnd_sat(mat[col][0], ov[0]);
      mcol.x = rnd_sat(mat[col][1], ov[1]);
      mcol.y = rnd_sat(mat[col][2], ov[2]);
    end
    mcol.fault = ov[0] | ov[1] | ov[2] | ov[3];
    mcol.last = (col == 2'd3);
  end

  // Inverse numerator: component moved to 2F fraction bits, doubled, plus |A|^2.
  always_comb begin
    word_t c;
    logic [WordBits-1:0] mag;
    unique case (inv_i)
      2'd0: c = s1_item.a_s;
      2'd1: c = s1_item.a_x;
      2'd2: c = s1_item.a_y;
      default: c = s1_item.a_z;
    endcase
    inv_neg = (inv_i == 2'd0) ? c[WordBits-1] : (c != '0) && !c[WordBits-1];
    mag = $unsigned(c[WordBits-1] ? -c : c);
    div_num = (DivBits'(mag) << (2 * FracBits + 1)) + DivBits'($unsigned(nrm));
    div_den = DivBits'($unsigned(nrm)) << 1;
  end

  qau_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Signed inverse quotient, saturated.
  word_t iq;
  logic  iq_ov;
  always_comb begin
    acc_t v;
    v = inv_neg ? -acc_t'(div_quo[WordBits-1:0]) : acc_t'(div_quo[WordBits-1:0]);
    if (div_quo[DivBits-1:WordBits] != '0) begin
      iq_ov = 1'b1;
      iq = inv_neg ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
    end else begin
      iq = sat_word(v, iq_ov);
    end
  end

  assign div_start = (st == ST_INV) && !div_busy && (nrm != '0) && !inv_all;

  // A result enters the output register in these cases.
  always_comb begin
    o_load = 1'b0;
    unique case (st)
      ST_RUN:  o_load = o_free && s1_valid && (s1_pass == 2'd0) && !s1_hold;
      ST_ROT2: o_load = o_free && s1_valid && (s1_pass == 2'd1);
      ST_INV:  o_load = o_free && (nrm == '0 || inv_all);
      ST_DIV:  o_load = 1'b0;
      default: o_load = o_free;
    endcase
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= o_load || (o_valid && !out_ready);
    end
  end

  // Sequencer and output data.
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ST_RUN;
      col     <= '0;
      inv_i   <= '0;
      inv_all <= 1'b0;
    end else begin
      unique case (st)
        ST_RUN: begin
          if (s1_valid && s1_pass == 2'd0 && o_free) begin
            priority case (1'b1)
              s1_item.bad || s1_item.kind == OP_ADD || s1_item.kind == OP_CONJ: begin
                o_res <= simple;
              end
              s1_item.kind == OP_MUL: begin
                o_res <= '{s: hr[0], x: hr[1], y: hr[2], z: hr[3],
                           fault: hov[0] | hov[1] | hov[2] | hov[3], last: 1'b1};
              end
              s1_item.kind == OP_ROT: begin
                pr   <= hr;
                pr_f <= hov[0] | hov[1] | hov[2] | hov[3];
                st   <= ST_ROT2;
              end
              s1_item.kind == OP_INV: begin
                nrm     <= acc_t'(p[0][0]) + acc_t'(p[1][1]) + acc_t'(p[2][2]) +
                           acc_t'(p[3][3]);
                inv_i   <= '0;
                inv_all <= 1'b0;
                inv_f   <= 1'b0;
                st      <= ST_INV;
              end
              default: begin
                mat[0][0] <= (acc_t'(1) <<< (2*FracBits)) - ((acc_t'(p[2][2]) + acc_t'(p[3][3])) <<< 1);
                mat[0][1] <= (acc_t'(p[0][3]) + acc_t'(p[1][2])) <<< 1;
                mat[0][2] <= (acc_t'(p[1][3]) - acc_t'(p[0][2])) <<< 1;
                mat[1][0] <= (acc_t'(p[1][2]) - acc_t'(p[0][3])) <<< 1;
                mat[1][1] <= (acc_t'(1) <<< (2*FracBits)) - ((acc_t'(p[1][1]) + acc_t'(p[3][3])) <<< 1);
                mat[1][2] <= (acc_t'(p[0][1]) + acc_t'(p[2][3])) <<< 1;
                mat[2][0] <= (acc_t'(p[0][2]) + acc_t'(p[1][3])) <<< 1;
                mat[2][1] <= (acc_t'(p[2][3]) - acc_t'(p[0][1])) <<< 1;
                mat[2][2] <= (acc_t'(1) <<< (2*FracBits)) - ((acc_t'(p[1][1]) + acc_t'(p[2][2])) <<< 1);
                col <= '0;
                st  <= ST_MAT;
              end
            endcase
          end
        end
        ST_ROT2: begin
          if (s1_valid && s1_pass == 2'd1 && o_free) begin
            o_res <= '{s: '0, x: hr[1], y: hr[2], z: hr[3],
                       fault: pr_f | hov[1] | hov[2] | hov[3], last: 1'b1};
            st <= ST_RUN;
          end
        end
        ST_INV: begin
          // Zero length gives a zero result with the fault flag.
          if (nrm == '0) begin
            if (o_free) begin
              o_res <= '{s: '0, x: '0, y: '0, z: '0, fault: 1'b1, last: 1'b1};
              st <= ST_RUN;
            end
          end else if (inv_all) begin
            if (o_free) begin
              o_res <= '{s: inv_r[0], x: inv_r[1], y: inv_r[2], z: inv_r[3],
                         fault: inv_f, last: 1'b1};
              st <= ST_RUN;
            end
          end else begin
            st <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            inv_r[inv_i] <= iq;
            inv_f <= inv_f | iq_ov;
            inv_i <= inv_i + 1'b1;
            if (inv_i == 2'd3) inv_all <= 1'b1;
            st <= ST_INV;
          end
        end
        default: begin
          if (o_free) begin
            o_res <= mcol;
            col   <= col + 1'b1;
            if (col == 2'd3) st <= ST_RUN;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/quaternion_arithmetic_unit.sv @@
// Quaternion arithmetic unit, signed Q8.24: add, product, conjugate, inverse,
// vector rotation and rotation matrix. Add, product and conjugate pass through
// the queue, product and output registers, one item per cycle unless the output
// stalls; rotate holds the back end for two product passes; matrix holds it while
// emitting four columns, one per cycle unless stalled; inverse runs four serial
// divisions. Reset (rst, synchronous) empties queue and pipe.
`default_nettype none
module quaternion_arithmetic_unit
  import qau_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // a_s, a_x, a_y, a_z, b_s, b_x, b_y, b_z from bit 0 up
  input  wire logic [255:0] s_tdata,
  // kind
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // res_s, res_x, res_y, res_z from bit 0 up
  output logic [127:0]      m_tdata,
  // fault
  output logic              m_tuser,
  output logic              m_tlast
);

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;
  res_t  res;

  // Unpack the input transaction.
  always_comb begin
    in_item.kind = s_tuser;
    in_item.bad  = 1'b0;
    in_item.a_s = s_tdata[31:0];    in_item.a_x = s_tdata[63:32];
    in_item.a_y = s_tdata[95:64];   in_item.a_z = s_tdata[127:96];
    in_item.b_s = s_tdata[159:128]; in_item.b_x = s_tdata[191:160];
    in_item.b_y = s_tdata[223:192]; in_item.b_z = s_tdata[255:224];
  end

  qau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  qau_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {res.z, res.y, res.x, res.s};
  assign m_tuser = res.fault;
  assign m_tlast = res.last;

endmodule
`default_nettype wire

@@ src/qau_checker.sv @@
// Port-level checker for the quaternion arithmetic unit, bound to the top
// level. Depends on qau_pkg only through the top level's ports.
`default_nettype none
module qau_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [127:0] m_tdata,
  input wire logic         m_tlast
);

  // A stalled result holds its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Nothing leaves in the first cycle after reset.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result out of an empty unit");

  // Handshake signals are always known outside reset.
  a_hs_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({s_tvalid, s_tready, m_tvalid, m_tready}))
    else $error("unknown handshake signal");

  // An offered result carries known data.
  a_res_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !$isunknown({m_tdata, m_tlast}))
    else $error("unknown result data");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

@@ verif/tb_quaternion_arithmetic_unit.sv @@
// Self-checking testbench for the quaternion arithmetic unit.
// Depends on qau_pkg and quaternion_arithmetic_unit; an exact wide-integer
// predictor computes every expected result column and a monitor checks them.
`timescale 1ns / 1ps
`default_nettype none
module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;

  typedef logic signed [127:0] wide_t;

  // Operation codes that the block does not define.
  localparam logic [2:0] KindSpareLo = 3'd6;
  localparam logic [2:0] KindSpareHi = 3'd7;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles = 300;

  localparam word_t WMax = 32'sh7fff_ffff;
  localparam word_t WMin = 32'sh8000_0000;
  localparam word_t One  = 32'sh0100_0000;
  localparam word_t Half = 32'sh0080_0000;

  typedef struct {
    logic [2:0] kind;
    word_t      a[4];
    word_t      b[4];
    logic       hold;
  } quat_item_t;

  typedef struct {
    word_t s;
    word_t x;
    word_t y;
    word_t z;
    logic  fault;
    logic  last;
  } column_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [255:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  quat_item_t pending_items[$];
  column_t expected_cols[$];
  quat_item_t in_flight;
  int mismatches = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_gap = 0;
  int recv_calm = 0;
  int idle_cycles = 0;

  quaternion_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #1 clk = ~clk;

  // Round by sh fraction bits (ties up), then saturate to one word.
  function automatic word_t fit_word(input wide_t v, input int sh, inout logic flt);
    wide_t t;
    wide_t lim;
    lim = wide_t'(1) <<< 31;
    t = (sh > 0) ? ((v + (wide_t'(1) <<< (sh - 1))) >>> sh) : v;
    if (t >= lim) begin
      flt = 1'b1;
      return WMax;
    end else if (t < -lim) begin
      flt = 1'b1;
      return WMin;
    end
    return t[31:0];
  endfunction

  // Exact Hamilton product p*q with wide operands.
  function automatic void hamilton(input wide_t p[4], input wide_t q[4], output wide_t o[4]);
    o[0] = p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3];
    o[1] = p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2];
    o[2] = p[0]*q[2] + p[2]*q[0] + p[3]*q[1] - p[1]*q[3];
    o[3] = p[0]*q[3] + p[3]*q[0] + p[1]*q[2] - p[2]*q[1];
  endfunction

  // Works out the result columns of one accepted transaction.
  function automatic void predict_columns(input quat_item_t it);
    wide_t a[4], b[4], w[4], v[4], pa[4], ca[4];
    wide_t sq, num, quo, one_w;
    wide_t m[4][4];
    word_t r[4];
    logic flt;
    logic neg;
    column_t col;
    for (int i = 0; i < 4; i++) begin
      a[i] = wide_t'(it.a[i]);
      b[i] = wide_t'(it.b[i]);
      r[i] = '0;
    end
    flt = 1'b0;
    one_w = wide_t'(1) <<< (2 * FracBits);
    case (it.kind)
      OP_ADD: for (int i = 0; i < 4; i++) r[i] = fit_word(a[i] + b[i], 0, flt);
      OP_MUL: begin
        hamilton(a, b, w);
        for (int i = 0; i < 4; i++) r[i] = fit_word(w[i], FracBits, flt);
      end
      OP_CONJ: begin
        r[0] = it.a[0];
        for (int i = 1; i < 4; i++) r[i] = fit_word(-a[i], 0, flt);
      end
      OP_INV: begin
        sq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
        if (sq == 0) begin
          flt = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            num = a[i] <<< (2 * FracBits);
            if (i > 0) num = -num;
            neg = num < 0;
            if (neg) num = -num;
            quo = (2 * num + sq) / (2 * sq);
            r[i] = fit_word(neg ? -quo : quo, 0, flt);
          end
        end
      end
      OP_ROT: begin
        v[0] = 0;
        for (int i = 1; i < 4; i++) v[i] = b[i];
        hamilton(a, v, w);
        for (int i = 0; i < 4; i++) pa[i] = wide_t'(fit_word(w[i], FracBits, flt));
        ca[0] = a[0];
        for (int i = 1; i < 4; i++) ca[i] = -a[i];
        hamilton(pa, ca, w);
        for (int i = 1; i < 4; i++) r[i] = fit_word(w[i], FracBits, flt);
      end
      OP_MAT: begin
        m[0][0] = one_w - 2*(a[2]*a[2] + a[3]*a[3]);
        m[0][1] = 2*(a[0]*a[3] + a[1]*a[2]);
        m[0][2] = 2*(a[1]*a[3] - a[0]*a[2]);
        m[1][0] = 2*(a[1]*a[2] - a[0]*a[3]);
        m[1][1] = one_w - 2*(a[1]*a[1] + a[3]*a[3]);
        m[1][2] = 2*(a[0]*a[1] + a[2]*a[3]);
        m[2][0] = 2*(a[0]*a[2] + a[1]*a[3]);
        m[2][1] = 2*(a[2]*a[3] - a[0]*a[1]);
        m[2][2] = one_w - 2*(a[1]*a[1] + a[2]*a[2]);
        for (int c = 0; c < 3; c++) begin
          m[c][3] = 0;
          m[3][c] = 0;
        end
        m[3][3] = one_w;
        for (int c = 0; c < 4; c++) begin
          flt = 1'b0;
          for (int i = 0; i < 4; i++) r[i] = fit_word(m[c][i], FracBits, flt);
          col = '{r[0], r[1], r[2], r[3], flt, c == 3};
          expected_cols.push_back(col);
        end
        return;
      end
      default: flt = 1'b1;
    endcase
    col = '{r[0], r[1], r[2], r[3], flt, 1'b1};
    expected_cols.push_back(col);
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic word_t pick_word();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return word_t'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    if (p < 60) return word_t'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
    if (p < 68) return WMax;
    if (p < 76) return WMin;
    if (p < 80) return '0;
    return word_t'($urandom);
  endfunction

  function automatic void add_item(input logic [2:0] kind, input word_t a0, a1, a2, a3,
                                   input word_t b0, b1, b2, b3);
    quat_item_t it;
    it.kind = kind;
    it.a = '{a0, a1, a2, a3};
    it.b = '{b0, b1, b2, b3};
    it.hold = 1'b0;
    pending_items.push_back(it);
  endfunction

  // Sender: offers the next pending transaction once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) predict_columns(in_flight);
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0 &&
                   !(pending_items[0].hold && expected_cols.size() > 0)) begin
        in_flight = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= in_flight.kind;
        s_tdata <= {in_flight.b[3], in_flight.b[2], in_flight.b[1], in_flight.b[0],
                    in_flight.a[3], in_flight.a[2], in_flight.a[1], in_flight.a[0]};
        if (send_calm > 0) begin
          send_calm <= send_calm - 1;
          send_gap <= 0;
        end else if ($urandom_range(0, 24) == 0) begin
          send_calm <= 30;
          send_gap <= 0;
        end else begin
          send_gap <= pick_gap();
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (recv_calm > 0) begin
        recv_calm <= recv_calm - 1;
      end else if ($urandom_range(0, 39) == 0) begin
        recv_calm <= 40;
      end else if ($urandom_range(0, 2) == 0) begin
        recv_gap <= pick_gap();
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    column_t want;
    column_t got;
    logic bad;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96], m_tuser,
              m_tlast};
      if (expected_cols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transaction: %h fault %b last %b", m_tdata, m_tuser,
                   m_tlast);
      end else begin
        want = expected_cols.pop_front();
        bad = (got.s !== want.s) || (got.x !== want.x) || (got.y !== want.y) ||
              (got.z !== want.z) || (got.fault !== want.fault) || (got.last !== want.last);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h %h %h %h f%b l%b, got %h %h %h %h f%b l%b",
                     want.s, want.x, want.y, want.z, want.fault, want.last,
                     got.s, got.x, got.y, got.z, got.fault, got.last);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [2:0] k;
    // Directed part: extremes, every operation and the special cases.
    add_item(OP_ADD, WMax, WMax, WMin, 0, WMax, 1, WMin, 0);
    add_item(OP_ADD, WMin, One, -One, 5, -1, One, One, -5);
    add_item(OP_MUL, WMax, WMax, WMax, WMax, WMax, WMax, WMax, WMax);
    add_item(OP_MUL, WMin, WMin, WMin, WMin, WMin, WMax, WMin, WMax);
    add_item(OP_MUL, One, Half, -One, 0, Half, One, 0, -One);
    add_item(OP_CONJ, WMin, WMin, WMax, 0, 0, 0, 0, 0);
    add_item(OP_CONJ, WMax, WMax, -1, 1, WMin, WMin, WMin, WMin);
    add_item(OP_INV, 0, 0, 0, 0, One, One, One, One);
    add_item(OP_INV, One, 0, 0, 0, 0, 0, 0, 0);
    add_item(OP_INV, One, One, -One, One, 0, 0, 0, 0);
    add_item(OP_INV, 1, 0, 0, 0, 0, 0, 0, 0);
    add_item(OP_INV, 0, 0, 0, -1, 0, 0, 0, 0);
    add_item(OP_INV, WMin, WMax, WMin, WMax, 0, 0, 0, 0);
    add_item(OP_ROT, Half, Half, Half, Half, WMax, One, 0, -One);
    add_item(OP_ROT, WMax, WMin, WMax, WMin, 0, WMax, WMin, WMax);
    add_item(OP_MAT, One, 0, 0, 0, 0, 0, 0, 0);
    add_item(OP_MAT, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(OP_MAT, Half, Half, Half, Half, 0, 0, 0, 0);
    add_item(OP_MAT, WMax, WMin, WMax, WMin, 0, 0, 0, 0);
    add_item(KindSpareLo, One, One, One, One, One, One, One, One);
    add_item(KindSpareHi, WMax, WMin, 0, 1, -1, 0, 0, 0);
    // Random part; one transaction waits for the block to drain first.
    for (int n = 0; n < 380; n++) begin
      k = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(KindSpareLo, KindSpareHi))
                                        : 3'($urandom_range(OP_ADD, OP_MAT));
      add_item(k, pick_word(), pick_word(), pick_word(), pick_word(),
               pick_word(), pick_word(), pick_word(), pick_word());
      if (n == 190) pending_items[pending_items.size() - 1].hold = 1'b1;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_items.size() == 0 && !s_tvalid);
    wait (expected_cols.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_cols.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
